// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// ===== sv/spimrb_pkg.sv =====
// Types and constants of the SPI master register block.
`timescale 1ns / 1ps

package spimrb_pkg;

    // Command codes of an input beat
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    // unassigned code, handled as a tick
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Register select codes
    localparam logic REG_DATA = 1'b0;
    localparam logic REG_CTRL = 1'b1;

    // Control register bit positions
    localparam int CTRL_KEEP_LSB = 6;
    localparam int CTRL_RUN_BIT  = 5;
    localparam int CTRL_CSN_BIT  = 4;
    localparam int CTRL_WR_BIT   = 3;

    // Input beat
    typedef struct packed {
        logic [1:0]  cmd;
        logic        reg_select;
        logic [31:0] write_value;
        logic        miso;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [31:0] read_value;
        logic        busy_res;
        logic        cs_n;
        logic        sclk;
        logic        mosi;
    } out_t;

endpackage

// ===== sv/spimrb_engine.sv =====
// Register file and serial engine: state update and result for one beat.
`timescale 1ns / 1ps

module spimrb_engine #(
    parameter int CLK_DIV   = 2,
    parameter int MAX_BYTES = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  spimrb_pkg::in_t   beat,
    output spimrb_pkg::out_t  result
);
    import spimrb_pkg::*;

    logic [31:0] data_reg,  data_next;
    logic [1:0]  kept_reg,  kept_next;
    logic        csn_reg,   csn_next;
    logic        wmode_reg, wmode_next;
    logic [2:0]  count_reg, count_next;
    logic        run_reg,   run_next;
    logic [4:0]  bit_reg,   bit_next;
    logic [7:0]  div_reg,   div_next;
    logic        clk_reg,   clk_next;

    // after the engine step, before the register access
    logic [31:0] data_s;
    logic        run_s;
    logic [4:0]  bit_s;
    logic [7:0]  div_s;
    logic        clk_s;

    logic [5:0]  last_bit;
    logic [2:0]  cnt_w;
    logic [7:0]  ctrl_w;
    logic [7:0]  ctrl_rd;

    // word bit of a serial bit index: lowest byte first, MSB first in a byte
    function automatic logic [4:0] word_pos(input logic [4:0] idx);
        word_pos = {idx[4:3], ~idx[2:0]};
    endfunction

    // Serial engine step
    always_comb begin
        data_s   = data_reg;
        run_s    = run_reg;
        bit_s    = bit_reg;
        div_s    = div_reg;
        clk_s    = clk_reg;
        last_bit = {count_reg, 3'b000} - 6'd1;
        if (run_reg) begin
            if (({1'b0, div_reg} + 9'd1) < 9'(CLK_DIV)) begin
                div_s = div_reg + 8'd1;
            end else begin
                div_s = '0;
                if (!clk_reg) begin
                    // rising edge: sample MISO on reads
                    clk_s = 1'b1;
                    if (!wmode_reg) begin
                        data_s[word_pos(bit_reg)] = beat.miso;
                    end
                end else begin
                    // falling edge: next bit, or done after the last one
                    clk_s = 1'b0;
                    if (count_reg == 3'd0 || {1'b0, bit_reg} >= last_bit) begin
                        run_s = 1'b0;
                        bit_s = '0;
                    end else begin
                        bit_s = bit_reg + 5'd1;
                    end
                end
            end
        end
    end

    // Register access
    always_comb begin
        data_next  = data_s;
        kept_next  = kept_reg;
        csn_next   = csn_reg;
        wmode_next = wmode_reg;
        count_next = count_reg;
        run_next   = run_s;
        bit_next   = bit_s;
        div_next   = div_s;
        clk_next   = clk_s;
        ctrl_w     = beat.write_value[7:0];
        cnt_w      = (ctrl_w[2:0] > 3'(MAX_BYTES)) ? 3'(MAX_BYTES) : ctrl_w[2:0];
        ctrl_rd    = {kept_reg, run_s, csn_reg, wmode_reg, count_reg};
        result.read_value = '0;
        unique case (beat.cmd)
            CMD_WRITE: begin
                // writes are dropped while a transfer runs
                if (!run_s) begin
                    if (beat.reg_select == REG_DATA) begin
                        data_next = beat.write_value;
                    end else begin
                        kept_next  = ctrl_w[7:CTRL_KEEP_LSB];
                        csn_next   = ctrl_w[CTRL_CSN_BIT];
                        wmode_next = ctrl_w[CTRL_WR_BIT];
                        count_next = cnt_w;
                        if (ctrl_w[CTRL_RUN_BIT] && cnt_w != 3'd0) begin
                            run_next = 1'b1;
                            bit_next = '0;
                            div_next = '0;
                            clk_next = 1'b0;
                        end
                    end
                end
            end
            CMD_READ: begin
                result.read_value = (beat.reg_select == REG_DATA) ? data_s
                                                                  : {24'd0, ctrl_rd};
            end
            default: begin
                // tick only
            end
        endcase
        result.busy_res = run_next;
        result.cs_n     = csn_next;
        result.sclk     = clk_next;
        result.mosi     = run_next && wmode_next && data_next[word_pos(bit_next)];
    end

    // State registers, advanced once per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg  <= '0;
            kept_reg  <= '0;
            csn_reg   <= 1'b1;
            wmode_reg <= 1'b0;
            count_reg <= '0;
            run_reg   <= 1'b0;
            bit_reg   <= '0;
            div_reg   <= '0;
            clk_reg   <= 1'b0;
        end else if (step) begin
            data_reg  <= data_next;
            kept_reg  <= kept_next;
            csn_reg   <= csn_next;
            wmode_reg <= wmode_next;
            count_reg <= count_next;
            run_reg   <= run_next;
            bit_reg   <= bit_next;
            div_reg   <= div_next;
            clk_reg   <= clk_next;
        end
    end

endmodule

// ===== sv/spi_master_register_block.sv =====
// Top level: SPI master register block with registered result channel.
// The result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless m_ready stalls the result channel; set by the single state update per beat.
// Input is taken whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous): engine state and result valid cleared, chip select high, idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spi_master_register_block #(
    parameter int CLK_DIV   = 2,
    parameter int MAX_BYTES = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spimrb_pkg::in_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output spimrb_pkg::out_t  m_data
);
    import spimrb_pkg::*;

    logic  step;
    out_t  result;
    logic  m_valid_reg;
    out_t  m_data_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    spimrb_engine #(
        .CLK_DIV   (CLK_DIV),
        .MAX_BYTES (MAX_BYTES)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .beat    (s_data),
        .result  (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg <= result;
        end
    end

    // Checks
    `ASSERT_CLK(a_accept_gives_result, aclk, aresetn, step |=> m_valid_reg,
        "accepted beat did not produce a result")
    `ASSERT_CLK(a_drain_empties, aclk, aresetn,
        (m_valid_reg && m_ready && !s_valid) |=> !m_valid_reg,
        "result register not emptied after drain")
    `ASSERT_NEVER(a_idle_pins_quiet, aclk, aresetn,
        m_valid_reg && !m_data_reg.busy_res && (m_data_reg.sclk || m_data_reg.mosi),
        "serial pins active while idle")

endmodule
